// ===== src/cvv_pkg.sv =====
// ----------------------------------------------------------------------------
// cvv_pkg: shared types and constants for the column vertical velocity block
// Word formats of both channels, the queue entry that passes from the front
// to the back end, the difference weight flags and register indexes.
// ----------------------------------------------------------------------------
package cvv_pkg;

  // Fixed word widths.
  localparam int DATA_WIDTH = 32;
  localparam int DIFF_W     = DATA_WIDTH + 1;  // difference of two data values
  localparam int INV_W      = 32;              // reciprocal spacing, Q0.32
  localparam int SPACING_W  = 31;              // level spacing, unsigned
  localparam int FLAG_W     = 5;

  // Defaults for the top level parameters.
  localparam int FRAC_BITS_DEFAULT   = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPSTREAM_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_X_SPACING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_Y_SPACING = 2'd2;

  // Bit positions in the ice flags.
  localparam int ICE_CENTER = 0;
  localparam int ICE_EAST   = 1;
  localparam int ICE_WEST   = 2;
  localparam int ICE_NORTH  = 3;
  localparam int ICE_SOUTH  = 4;

  // Which sides take part in the horizontal differences.
  typedef struct packed {
    logic north;
    logic south;
    logic east;
    logic west;
  } weights_t;

  // One input word: one level of one column.
  typedef struct packed {
    logic                        first_level;
    logic                        last_level;
    logic [FLAG_W-1:0]           ice_flags;
    logic signed [DATA_WIDTH-1:0] basal_melt;
    logic [SPACING_W-1:0]        level_spacing;
    logic signed [DATA_WIDTH-1:0] u_west;
    logic signed [DATA_WIDTH-1:0] u_center;
    logic signed [DATA_WIDTH-1:0] u_east;
    logic signed [DATA_WIDTH-1:0] v_south;
    logic signed [DATA_WIDTH-1:0] v_center;
    logic signed [DATA_WIDTH-1:0] v_north;
  } level_t;

  // One output word.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] vert_velocity;
    logic                         column_done;
  } result_t;

  // A classified level, ready for the arithmetic back end.
  typedef struct packed {
    logic                         first_level;
    logic                         last_level;
    logic signed [DATA_WIDTH-1:0] basal_melt;
    logic [SPACING_W-1:0]         level_spacing;
    logic signed [DIFF_W-1:0]     dx;       // weighted x difference sum
    logic                         dx_both;  // both x sides used: halve
    logic signed [DIFF_W-1:0]     dy;
    logic                         dy_both;
  } job_t;

endpackage

// ===== src/cvv_front.sv =====
// ----------------------------------------------------------------------------
// cvv_front: level classification
// Accepts one level word per cycle while the queue is not full, picks the
// difference weights on the base level of a column and forms the x and y
// difference sums for the back end.
module cvv_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            level_valid,
  output logic            level_stall,
  input  cvv_pkg::level_t level,
  input  logic            upstream_mode,
  input  logic            q_full,
  output logic            q_push,
  output cvv_pkg::job_t   q_data
);
  import cvv_pkg::*;

  weights_t weight_flags;
  weights_t wf_new;
  weights_t wf_use;
  logic [1:0] x_dir;
  logic [1:0] y_dir;
  logic signed [DIFF_W-1:0] uw, uc, ue, vs, vc, vn;
  logic ctr;

  // Upwind choice: lower side only, upper side only, or both (returned {hi, lo}).
  function automatic logic [1:0] pick_dir(input logic signed [DIFF_W-1:0] s_lo,
                                          input logic signed [DIFF_W-1:0] s_hi);
    logic [1:0] dir;
    if (s_lo > 0 && s_hi >= 0) begin
      dir = 2'b01;
    end else if (s_lo <= 0 && s_hi < 0) begin
      dir = 2'b10;
    end else begin
      dir = 2'b11;
    end
    return dir;
  endfunction

  assign level_stall = q_full;
  assign q_push      = level_valid && !q_full;

  // Widen the velocities so that sums and differences cannot wrap.
  assign uw = DIFF_W'(level.u_west);
  assign uc = DIFF_W'(level.u_center);
  assign ue = DIFF_W'(level.u_east);
  assign vs = DIFF_W'(level.v_south);
  assign vc = DIFF_W'(level.v_center);
  assign vn = DIFF_W'(level.v_north);
  assign ctr = level.ice_flags[ICE_CENTER];

  // Weight choice for a new column, then masking at the ice margin.
  always_comb begin
    x_dir = pick_dir(uw + uc, uc + ue);
    y_dir = pick_dir(vs + vc, vc + vn);
    wf_new = '1;
    if (upstream_mode) begin
      wf_new.west  = x_dir[0];
      wf_new.east  = x_dir[1];
      wf_new.south = y_dir[0];
      wf_new.north = y_dir[1];
    end
    if (level.ice_flags[ICE_EAST] != ctr) begin
      wf_new.east = 1'b0;
    end
    if (level.ice_flags[ICE_WEST] != ctr) begin
      wf_new.west = 1'b0;
    end
    if (level.ice_flags[ICE_NORTH] != ctr) begin
      wf_new.north = 1'b0;
    end
    if (level.ice_flags[ICE_SOUTH] != ctr) begin
      wf_new.south = 1'b0;
    end
    wf_use = level.first_level ? wf_new : weight_flags;
  end

  // Difference sums for the chosen sides.
  always_comb begin
    q_data.first_level   = level.first_level;
    q_data.last_level    = level.last_level;
    q_data.basal_melt    = level.basal_melt;
    q_data.level_spacing = level.level_spacing;
    q_data.dx_both       = 1'b0;
    q_data.dy_both       = 1'b0;
    case ({wf_use.west, wf_use.east})
      2'b11: begin
        q_data.dx      = ue - uw;
        q_data.dx_both = 1'b1;
      end
      2'b10:   q_data.dx = uc - uw;
      2'b01:   q_data.dx = ue - uc;
      default: q_data.dx = '0;
    endcase
    case ({wf_use.south, wf_use.north})
      2'b11: begin
        q_data.dy      = vn - vs;
        q_data.dy_both = 1'b1;
      end
      2'b10:   q_data.dy = vc - vs;
      2'b01:   q_data.dy = vn - vc;
      default: q_data.dy = '0;
    endcase
  end

  // The weights hold for the whole column.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_flags <= '1;
    end else if (q_push && level.first_level) begin
      weight_flags <= wf_new;
    end
  end

  a_weights_hold: assert property (@(posedge clk) disable iff (rst)
    !(q_push && level.first_level) |=> $stable(weight_flags))
    else $error("weight flags changed without a new column");

endmodule

// ===== src/cvv_queue.sv =====
// ----------------------------------------------------------------------------
// cvv_queue: classified level queue
// A short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module cvv_queue #(
  parameter int DEPTH = cvv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cvv_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output cvv_pkg::job_t pop_data,
  output logic          empty
);
  import cvv_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");

endmodule

// ===== src/cvv_back.sv =====
// ----------------------------------------------------------------------------
// cvv_back: divergence and column integration
// Takes one classified level at a time from the queue, scales the difference
// sums into the divergence and advances the trapezoid integral of the column.
// ----------------------------------------------------------------------------
module cvv_back #(
  parameter int FRAC_BITS = cvv_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cvv_pkg::INV_W-1:0]   inv_x_spacing,
  input  logic [cvv_pkg::INV_W-1:0]   inv_y_spacing,
  input  logic                        q_empty,
  input  cvv_pkg::job_t               q_data,
  output logic                        q_pop,
  output logic                        result_valid,
  input  logic                        result_stall,
  output cvv_pkg::result_t            result
);
  import cvv_pkg::*;

  localparam int PROD_W  = DIFF_W + INV_W;         // scaled difference product
  localparam int RND_W   = PROD_W + 1 - INV_W;     // rounded derivative magnitude
  localparam int DER_W   = RND_W + 1;              // signed derivative
  localparam int ZPROD_W = DIFF_W + SPACING_W;     // trapezoid step product
  localparam int WIDE_W  = 2 * DATA_WIDTH + 2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_RND  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_STEP = 6'b010000,
    ST_ACC  = 6'b100000
  } state_t;

  state_t                       state;
  job_t                         job;
  logic [PROD_W-1:0]            prod_x, prod_y;
  logic signed [DER_W-1:0]      ux, vy;
  logic signed [DATA_WIDTH-1:0] prev_div;
  logic signed [DIFF_W-1:0]     pair_sum;
  logic [ZPROD_W-1:0]           prod_z;
  logic signed [DATA_WIDTH-1:0] running_w;

  logic [DIFF_W-1:0]            mag_x, mag_y, mag_z;
  logic [PROD_W:0]              add_x, add_y;
  logic [RND_W-1:0]             r_x, r_y;
  logic signed [DER_W-1:0]      ux_c, vy_c;
  logic signed [DATA_WIDTH-1:0] div_c;
  logic [ZPROD_W:0]             add_z;
  logic signed [WIDE_W-1:0]     step_c, w_sum_c;
  logic signed [DATA_WIDTH-1:0] w_next;
  logic                         can_write;

  // Saturate a wide signed value to the data width.
  function automatic logic signed [DATA_WIDTH-1:0] sat_data(
      input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi_lim;
    logic signed [WIDE_W-1:0] lo_lim;
    hi_lim = {{(WIDE_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // Magnitude of a difference-width value, read as unsigned.
  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(~v + 1'b1) : v;
  endfunction

  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign can_write = !result_valid || !result_stall;

  // Magnitudes feeding the multipliers.
  assign mag_x = mag(job.dx);
  assign mag_y = mag(job.dy);
  assign mag_z = mag(pair_sum);

  // Round to nearest on the magnitude, halving again when both sides count.
  always_comb begin
    add_x = {1'b0, prod_x} + (job.dx_both ? (PROD_W + 1)'(1) << INV_W
                                          : (PROD_W + 1)'(1) << (INV_W - 1));
    add_y = {1'b0, prod_y} + (job.dy_both ? (PROD_W + 1)'(1) << INV_W
                                          : (PROD_W + 1)'(1) << (INV_W - 1));
    r_x = RND_W'(job.dx_both ? add_x >> (INV_W + 1) : add_x >> INV_W);
    r_y = RND_W'(job.dy_both ? add_y >> (INV_W + 1) : add_y >> INV_W);
    ux_c = job.dx[DIFF_W-1] ? -$signed({1'b0, r_x}) : $signed({1'b0, r_x});
    vy_c = job.dy[DIFF_W-1] ? -$signed({1'b0, r_y}) : $signed({1'b0, r_y});
  end

  // Saturated horizontal divergence.
  assign div_c = sat_data(WIDE_W'(ux) + WIDE_W'(vy));

  // Trapezoid step and the new vertical velocity.
  always_comb begin
    add_z  = {1'b0, prod_z} + ((ZPROD_W + 1)'(1) << FRAC_BITS);
    step_c = $signed(WIDE_W'(add_z >> (FRAC_BITS + 1)));
    if (job.first_level) begin
      w_sum_c = -WIDE_W'(job.basal_melt);
    end else if (pair_sum[DIFF_W-1]) begin
      w_sum_c = WIDE_W'(running_w) + step_c;
    end else begin
      w_sum_c = WIDE_W'(running_w) - step_c;
    end
    w_next = sat_data(w_sum_c);
  end

  // Sequencer: one level goes through all steps before the next is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      running_w    <= '0;
      prev_div     <= '0;
    end else begin
      if (state == ST_ACC && can_write) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:  state <= ST_RND;
        ST_RND:  state <= ST_SUM;
        ST_SUM: begin
          prev_div <= div_c;
          state    <= ST_STEP;
        end
        ST_STEP: state <= ST_ACC;
        ST_ACC: begin
          if (can_write) begin
            running_w <= w_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_data;
    end
    if (state == ST_MUL) begin
      prod_x <= {{INV_W{1'b0}}, mag_x} * {{DIFF_W{1'b0}}, inv_x_spacing};
      prod_y <= {{INV_W{1'b0}}, mag_y} * {{DIFF_W{1'b0}}, inv_y_spacing};
    end
    if (state == ST_RND) begin
      ux <= ux_c;
      vy <= vy_c;
    end
    if (state == ST_SUM) begin
      pair_sum <= DIFF_W'(div_c) + DIFF_W'(prev_div);
    end
    if (state == ST_STEP) begin
      prod_z <= {{SPACING_W{1'b0}}, mag_z} * {{DIFF_W{1'b0}}, job.level_spacing};
    end
    if (state == ST_ACC && can_write) begin
      result.vert_velocity <= w_next;
      result.column_done   <= job.last_level;
    end
  end

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_MUL)
    else $error("queue pop did not start a level");
  a_w_holds: assert property (@(posedge clk) disable iff (rst)
    (state != ST_ACC) |=> $stable(running_w))
    else $error("running velocity changed outside the integrate step");
  a_acc_writes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && can_write) |=> result_valid && state == ST_IDLE)
    else $error("integrate step did not deliver a word");

endmodule

// ===== src/column_vertical_velocity.sv =====
// ----------------------------------------------------------------------------
// column_vertical_velocity: vertical velocity of an ice column
// Streams column levels from the base upward and returns the vertical
// velocity at each level from the horizontal divergence of the velocities.
// ----------------------------------------------------------------------------
// Levels of one column arrive from the base upward, one word per level, with
// the first word of each column flagged. The base level sets the difference
// weights (upwind or centered, then masked where a neighbor's ice flag
// differs) and starts the integral at minus the basal melt rate; each later
// level subtracts a trapezoid step of its level spacing times the mean of
// this and the previous divergence. Every level gives one output word,
// flagged on the top level. The front end takes one level per cycle until
// its queue of QUEUE_DEPTH entries is full; the back end takes one level at
// a time and steps it through queue read, the two scaling products,
// rounding, divergence sum, step product and integration, and reads the
// next level only after integration, which waits while the output stalls.
// Configuration registers are written through cfg_valid/cfg_ready, which is
// always ready; write them only while no level is in flight.
// ----------------------------------------------------------------------------
module column_vertical_velocity #(
  parameter int FRAC_BITS   = cvv_pkg::FRAC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = cvv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             level_valid,
  output logic                             level_stall,
  input  cvv_pkg::level_t                  level,
  output logic                             result_valid,
  input  logic                             result_stall,
  output cvv_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cvv_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [cvv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import cvv_pkg::*;

  logic             upstream_mode;
  logic [INV_W-1:0] inv_x_spacing;
  logic [INV_W-1:0] inv_y_spacing;
  logic             q_push, q_full, q_pop, q_empty;
  job_t             q_in, q_out;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      upstream_mode <= 1'b0;
      inv_x_spacing <= '0;
      inv_y_spacing <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UPSTREAM_MODE: upstream_mode <= cfg_data[0];
        CFG_INV_X_SPACING: inv_x_spacing <= INV_W'(cfg_data);
        CFG_INV_Y_SPACING: inv_y_spacing <= INV_W'(cfg_data);
        default: ;
      endcase
    end
  end

  cvv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .level_valid   (level_valid),
    .level_stall   (level_stall),
    .level         (level),
    .upstream_mode (upstream_mode),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  cvv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  cvv_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .inv_x_spacing (inv_x_spacing),
    .inv_y_spacing (inv_y_spacing),
    .q_empty       (q_empty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule
